FILE: design/arpht_pkg.sv
// Shared types and constants for the ARP hash table.
// Transaction structs, table entry layout, controller/datapath command and status.
`timescale 1ns / 1ps

package arpht_pkg;

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] HASH_MULT = 32'h0100_0193;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] ip_address;
    logic [47:0] mac_value;
  } req_t;

  typedef struct packed {
    logic        success;
    logic [47:0] mac_found;
    logic [31:0] miss_total;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] address;
    logic [47:0] mac;
  } entry_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic hash_step;
    logic mod_step;
    logic probe_start;
    logic probe_next;
    logic write_en;
    logic miss_inc;
    logic res_load;
    logic res_success;
    logic res_mac_sel;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic clear_last;
    logic hash_last;
    logic mod_last;
    logic depth_pow2;
    logic probe_last;
    logic hit_empty;
    logic hit_match;
  } sts_t;

endpackage

FILE: design/arpht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module arpht_ram #(
  parameter int unsigned WIDTH = 81,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/arpht_dp.sv
// Datapath: FNV-1a hash unit, reciprocal slot reduction, probe counters, table RAM,
// miss counter and result/output registers. Uses arpht_pkg and arpht_ram.
`timescale 1ns / 1ps

module arpht_dp import arpht_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned PROBE_LIMIT = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t in_data_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output rsp_t out_data_o
);

  localparam int unsigned SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned PW = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_DEPTH - 1);
  localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / TABLE_DEPTH);
  localparam logic [PW-1:0] LAST_PROBE = PW'(PROBE_LIMIT - 1);
  localparam logic DEPTH_POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);

  req_t          req_q;
  logic [31:0]   hash_q, hash_d;
  logic [1:0]    byte_q;
  logic [1:0]    mod_cnt_q;
  logic [31:0]   red_q;
  logic [SW-1:0] rem_q, rem_d;
  logic [SW-1:0] slot_q, slot_next, home, rd_addr, wr_addr;
  logic [PW-1:0] pcnt_q;
  logic [SW-1:0] clr_q;
  logic [31:0]   miss_q;
  logic          res_success_q;
  logic [47:0]   res_mac_q;
  rsp_t          out_q;

  logic [7:0]    byte_sel;
  logic [31:0]   mix;
  logic [63:0]   recip_prod;
  logic [31:0]   red_fix;
  entry_t        rd_entry, wr_entry;
  logic [$bits(entry_t)-1:0] rdata;

  assign byte_sel = req_q.ip_address[{byte_q, 3'b000} +: 8];
  assign mix      = hash_q ^ {24'd0, byte_sel};

  always_comb begin
    hash_d = hash_q;
    if (cmd_i.load) begin
      hash_d = FNV_BASIS;
    end else if (cmd_i.hash_step) begin
      hash_d = mix * HASH_MULT;
    end
  end

  // quotient estimate from the reciprocal is low by at most one,
  // so one multiply-subtract and one correction give the remainder
  assign recip_prod = {32'd0, hash_q} * {32'd0, RECIP};
  assign red_fix    = (red_q >= DEPTH_W) ? (red_q - DEPTH_W) : red_q;
  assign rem_d      = red_fix[SW-1:0];

  assign home      = DEPTH_POW2 ? hash_q[SW-1:0] : rem_q;
  assign slot_next = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
  assign rd_addr   = cmd_i.probe_start ? home : slot_next;
  assign wr_addr   = cmd_i.clear_step ? clr_q : slot_q;

  always_comb begin
    wr_entry = '0;
    if (!cmd_i.clear_step) begin
      wr_entry.valid   = 1'b1;
      wr_entry.address = req_q.ip_address;
      wr_entry.mac     = req_q.mac_value;
    end
  end

  arpht_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.write_en | cmd_i.clear_step),
    .waddr_i(wr_addr),
    .wdata_i(wr_entry),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  assign rd_entry = entry_t'(rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q    <= '0;
      mod_cnt_q <= '0;
      pcnt_q    <= '0;
      clr_q     <= '0;
      miss_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        byte_q    <= '0;
        mod_cnt_q <= '0;
      end else begin
        if (cmd_i.hash_step) begin
          byte_q <= byte_q + 1'b1;
        end
        if (cmd_i.mod_step) begin
          mod_cnt_q <= mod_cnt_q + 1'b1;
        end
      end
      if (cmd_i.probe_start) begin
        pcnt_q <= '0;
      end else if (cmd_i.probe_next) begin
        pcnt_q <= pcnt_q + 1'b1;
      end
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.miss_inc) begin
        miss_q <= miss_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    if (cmd_i.load) begin
      req_q <= in_data_i;
      rem_q <= '0;
    end else if (cmd_i.mod_step) begin
      if (mod_cnt_q == 2'd0) begin
        red_q <= recip_prod[63:32];
      end else if (mod_cnt_q == 2'd1) begin
        red_q <= hash_q - red_q * DEPTH_W;
      end else begin
        rem_q <= rem_d;
      end
    end
    if (cmd_i.probe_start) begin
      slot_q <= home;
    end else if (cmd_i.probe_next) begin
      slot_q <= slot_next;
    end
    if (cmd_i.res_load) begin
      res_success_q <= cmd_i.res_success;
      res_mac_q     <= cmd_i.res_mac_sel ? rd_entry.mac : '0;
    end
    if (cmd_i.out_load) begin
      out_q.success    <= res_success_q;
      out_q.mac_found  <= res_mac_q;
      out_q.miss_total <= miss_q;
    end
  end

  assign sts_o.kind       = req_q.kind;
  assign sts_o.clear_last = (clr_q == LAST_SLOT);
  assign sts_o.hash_last  = (byte_q == 2'd3);
  assign sts_o.mod_last   = (mod_cnt_q == 2'd2);
  assign sts_o.depth_pow2 = DEPTH_POW2;
  assign sts_o.probe_last = (pcnt_q == LAST_PROBE);
  assign sts_o.hit_empty  = !rd_entry.valid;
  assign sts_o.hit_match  = rd_entry.valid && (rd_entry.address == req_q.ip_address);

  assign out_data_o = out_q;

endmodule

FILE: design/arpht_ctrl.sv
// Controller state machine: clear sweep, hash, slot reduction, probing, result handoff.
// Uses arpht_pkg; drives the datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module arpht_ctrl import arpht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (sts_i.hash_last) begin
          state_d = sts_i.depth_pow2 ? S_PROBE : S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd_o.probe_start = 1'b1;
        state_d           = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.kind == KIND_INSERT) begin
          if (sts_i.hit_empty || sts_i.hit_match) begin
            cmd_o.write_en    = 1'b1;
            cmd_o.res_load    = 1'b1;
            cmd_o.res_success = 1'b1;
            state_d           = S_OUT;
          end else if (sts_i.probe_last) begin
            cmd_o.res_load = 1'b1;
            state_d        = S_OUT;
          end else begin
            cmd_o.probe_next = 1'b1;
          end
        end else begin
          if (sts_i.hit_empty) begin
            cmd_o.res_load = 1'b1;
            state_d        = S_OUT;
          end else if (sts_i.hit_match) begin
            cmd_o.res_load    = 1'b1;
            cmd_o.res_success = 1'b1;
            cmd_o.res_mac_sel = 1'b1;
            state_d           = S_OUT;
          end else if (sts_i.probe_last) begin
            cmd_o.miss_inc = 1'b1;
            cmd_o.res_load = 1'b1;
            state_d        = S_OUT;
          end else begin
            cmd_o.probe_next = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_starts_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q == S_HASH))
    else $error("accepted transaction did not start hashing");

  a_write_only_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write_en |-> (sts_i.kind == KIND_INSERT && (sts_i.hit_empty || sts_i.hit_match)))
    else $error("table write without a free or matching slot");

  a_miss_only_exhausted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.miss_inc |-> (sts_i.kind == KIND_LOOKUP && !sts_i.hit_empty && !sts_i.hit_match
                        && sts_i.probe_last))
    else $error("miss counted before all probes were used");

  a_out_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result load did not raise output valid");

  a_no_overwrite_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.out_load)
    else $error("pending result overwritten");

endmodule

FILE: design/arp_hash_table_linear_probe.sv
// IPv4-to-MAC hash table with FNV-1a home slot and bounded linear probing.
// Channels:
//   in  : in_valid_i / in_stall_o / in_data_i  (req_t: kind, ip_address, mac_value)
//   out : out_valid_o / out_stall_i / out_data_o (rsp_t: success, mac_found, miss_total)
//   A transaction moves on a rising edge with valid high and stall low.
// One item is in flight at a time. After acceptance: hashing, one byte per
// cycle through a 32x32 multiplier; reciprocal slot reduction (quotient
// estimate, multiply-subtract, correction) when TABLE_DEPTH is not a power of
// two; a start state that issues the first table read; then one to PROBE_LIMIT
// probes (one RAM read each); then a load into the output register.
// The result sits in an output register; the next item is accepted while it
// waits. If out_stall_i holds, a finished result waits in the datapath result
// registers and no further item is accepted until the output register frees up.
// Reset: the controller sweeps the table clearing every entry, one per cycle;
// in_stall_o stays high until the sweep is done. The miss counter resets to
// zero.
// Uses arpht_pkg, arpht_ctrl, arpht_dp.
`timescale 1ns / 1ps

module arp_hash_table_linear_probe import arpht_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned PROBE_LIMIT = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  arpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  arpht_dp #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .PROBE_LIMIT(PROBE_LIMIT)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_data_o(out_data_o)
  );

endmodule

FILE: test/arpht_checker.sv
// Watches both channels of the ARP hash table, predicts every response from
// its own copy of the table and miss counter, and counts mismatches.
// Depends on arpht_pkg for req_t, rsp_t, the FNV constants and the kind codes.
`timescale 1ns / 1ps

module arpht_checker import arpht_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned PROBE_LIMIT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  req_t        in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  rsp_t        out_data_i,
  output int unsigned outstanding_o,
  output int unsigned fail_count_o
);

  bit          slot_used [TABLE_DEPTH];
  logic [31:0] slot_ip   [TABLE_DEPTH];
  logic [47:0] slot_mac  [TABLE_DEPTH];
  logic [31:0] miss_count = '0;
  rsp_t        expected_rsp_q [$];
  int unsigned errors = 0;

  initial begin
    outstanding_o = 0;
    fail_count_o  = 0;
  end

  function automatic logic [31:0] fnv1a_of(logic [31:0] ip);
    logic [31:0] h;
    int unsigned k;
    h = FNV_BASIS;
    for (k = 0; k < 4; k++) h = (h ^ {24'd0, ip[8*k +: 8]}) * HASH_MULT;
    return h;
  endfunction

  // Applies one request to the table copy and returns the response it yields.
  function automatic rsp_t resolve_request(req_t r);
    rsp_t        res;
    int unsigned home;
    int unsigned s;
    int unsigned i;
    logic        done;
    res  = '0;
    done = 1'b0;
    home = fnv1a_of(r.ip_address) % TABLE_DEPTH;
    for (i = 0; i < PROBE_LIMIT && !done; i++) begin
      s = (home + i) % TABLE_DEPTH;
      if (r.kind == KIND_INSERT) begin
        if (!slot_used[s] || slot_ip[s] == r.ip_address) begin
          slot_used[s] = 1'b1;
          slot_ip[s]   = r.ip_address;
          slot_mac[s]  = r.mac_value;
          res.success  = 1'b1;
          done         = 1'b1;
        end
      end else if (!slot_used[s]) begin
        done = 1'b1;
      end else if (slot_ip[s] == r.ip_address) begin
        res.success   = 1'b1;
        res.mac_found = slot_mac[s];
        done          = 1'b1;
      end
    end
    if (r.kind == KIND_LOOKUP && !done) miss_count = miss_count + 32'd1;
    res.miss_total = miss_count;
    return res;
  endfunction

  always @(posedge clk_i) begin : watch
    rsp_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response transaction with none expected: %h", out_data_i);
          errors++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_data_i.success !== want.success) begin
            $error("success: expected %0b, actual %0b", want.success, out_data_i.success);
            errors++;
          end
          if (out_data_i.mac_found !== want.mac_found) begin
            $error("mac_found: expected %h, actual %h", want.mac_found, out_data_i.mac_found);
            errors++;
          end
          if (out_data_i.miss_total !== want.miss_total) begin
            $error("miss_total: expected %0d, actual %0d",
                   want.miss_total, out_data_i.miss_total);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_rsp_q.push_back(resolve_request(in_data_i));
    end
    outstanding_o <= expected_rsp_q.size();
    fail_count_o  <= errors;
  end

endmodule

FILE: test/arp_hash_table_linear_probe_tb.sv
// Top of the ARP hash table testbench: clock, reset, request stimulus and
// response stalls; the verdict comes from the failure count of arpht_checker.
// Depends on arpht_pkg, arpht_checker and arp_hash_table_linear_probe.
`timescale 1ns / 1ps

module arp_hash_table_linear_probe_tb;
  import arpht_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned PROBE_LIMIT = 8;
  localparam int unsigned ITEM_COUNT  = 1350;

  typedef enum int unsigned {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid = 1'b0;
  logic        in_stall;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rsp_t        out_data;
  int unsigned outstanding;
  int unsigned fail_count;

  int unsigned sent = 0;
  int unsigned burst_left = 0;
  logic [31:0] inserted_ips [$];
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left = 0;

  always #10 clk = ~clk;

  arp_hash_table_linear_probe #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .PROBE_LIMIT(PROBE_LIMIT)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  arpht_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .PROBE_LIMIT(PROBE_LIMIT)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .outstanding_o(outstanding),
    .fail_count_o (fail_count)
  );

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ($urandom_range(0, 11) == 0) ? ~out_stall : out_stall;
    endcase
  end

  function automatic logic [47:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  // lookup_weight out of 4 gives the share of lookups
  function automatic logic rand_kind(int unsigned lookup_weight);
    return ($urandom_range(0, 3) < lookup_weight) ? KIND_LOOKUP : KIND_INSERT;
  endfunction

  // Random address whose home slot lies in [base, base + span), wrapping.
  function automatic logic [31:0] ip_near(int unsigned base, int unsigned span);
    logic [31:0] h;
    logic [31:0] ip;
    int unsigned k;
    do begin
      ip = $urandom();
      h  = FNV_BASIS;
      for (k = 0; k < 4; k++) h = (h ^ {24'd0, ip[8*k +: 8]}) * HASH_MULT;
    end while ((h % TABLE_DEPTH + TABLE_DEPTH - base) % TABLE_DEPTH >= span);
    return ip;
  endfunction

  task automatic send_item(input logic k, input logic [31:0] ip, input logic [47:0] mac);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{kind: k, ip_address: ip, mac_value: mac};
    do @(posedge clk); while (in_stall);
    sent++;
    if (k == KIND_INSERT) begin
      inserted_ips.push_back(ip);
      if (inserted_ips.size() > 128) void'(inserted_ips.pop_front());
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    logic [31:0] cluster [$];
    logic [31:0] ip;
    int unsigned n;
    int unsigned pick;
    int unsigned seg_len;
    int unsigned base;
    int unsigned span;

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_item(KIND_INSERT, 32'h0000_0000, 48'h0);
    send_item(KIND_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_item(KIND_LOOKUP, 32'h0000_0000, rand_mac());
    send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 48'h0);
    send_item(KIND_LOOKUP, 32'h0000_0001, 48'hFFFF_FFFF_FFFF);
    send_item(KIND_INSERT, 32'hFFFF_FFFF, 48'h1234_5678_9ABC);
    send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 48'h0);

    // all on the last home slot: probes wrap to slot 0, the last insert finds no room
    for (n = 0; n < PROBE_LIMIT + 2; n++) cluster.push_back(ip_near(TABLE_DEPTH - 1, 1));
    for (n = 0; n <= PROBE_LIMIT; n++) send_item(KIND_INSERT, cluster[n], rand_mac());
    send_item(KIND_LOOKUP, cluster[PROBE_LIMIT + 1], rand_mac());
    send_item(KIND_LOOKUP, cluster[PROBE_LIMIT], 48'h0);
    send_item(KIND_LOOKUP, cluster[PROBE_LIMIT - 1], 48'h0);
    send_item(KIND_INSERT, cluster[2], 48'h0);
    send_item(KIND_LOOKUP, cluster[2], 48'hFFFF_FFFF_FFFF);
    drain_results();

    while (sent < ITEM_COUNT) begin
      pick    = $urandom_range(0, 9);
      seg_len = $urandom_range(8, 36);
      if (pick < 6) begin
        base = $urandom_range(0, TABLE_DEPTH - 1);
        span = $urandom_range(1, 6);
        cluster.delete();
        repeat ($urandom_range(3, 10)) cluster.push_back(ip_near(base, span));
        repeat (seg_len) begin
          ip = ($urandom_range(0, 9) == 0) ? $urandom()
                                           : cluster[$urandom_range(0, cluster.size() - 1)];
          send_item(rand_kind(2), ip, rand_mac());
        end
      end else if (pick < 8) begin
        repeat (seg_len) begin
          ip = (inserted_ips.size() == 0) ? $urandom()
               : inserted_ips[$urandom_range(0, inserted_ips.size() - 1)];
          send_item(rand_kind(3), ip, rand_mac());
        end
      end else if (pick == 8) begin
        repeat (seg_len) send_item(rand_kind(2), $urandom(), rand_mac());
      end else begin
        repeat (seg_len / 4 + 1) begin
          case ($urandom_range(0, 3))
            0:       ip = 32'h0000_0000;
            1:       ip = 32'hFFFF_FFFF;
            2:       ip = 32'd1 << $urandom_range(0, 31);
            default: ip = ~(32'd1 << $urandom_range(0, 31));
          endcase
          send_item(rand_kind(2), ip, ($urandom_range(0, 1) == 0) ? 48'h0 : 48'hFFFF_FFFF_FFFF);
        end
      end
      if ($urandom_range(0, 7) == 0) drain_results();
    end

    drain_results();
    repeat (PROBE_LIMIT + 12) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: files.f
design/arpht_pkg.sv
design/arpht_ram.sv
design/arpht_dp.sv
design/arpht_ctrl.sv
design/arp_hash_table_linear_probe.sv
test/arpht_checker.sv
test/arp_hash_table_linear_probe_tb.sv
